[sv/np_clip_pkg.sv]
`timescale 1ns / 1ps
package np_clip_pkg;

    localparam int unsigned Q_FRAC   = 16;
    localparam int unsigned TQ_BITS  = 17;
    localparam int unsigned OQ_BITS  = 32;
    localparam int unsigned REM_W    = 51;
    localparam int unsigned DSOR_W   = 36;
    localparam int unsigned CMP_W    = REM_W + 17;
    localparam logic signed [34:0] Q_ONE_W  = 35'sd65536;
    localparam logic signed [35:0] NEAR_ONE = 36'sd65543;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } vtx_t;

    // Source of one strip position: a plain vertex (a) or the cut of edge a-b.
    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic       cut;
    } src_t;

    typedef struct packed {
        logic             hit;
        logic [REM_W-1:0] rem;
    } qs_t;

    function automatic src_t slot_src(input logic [2:0] mask, input logic [1:0] k);
        src_t s;
        s.a   = (k == 2'd3) ? 2'd2 : k;
        s.b   = s.a;
        s.cut = 1'b0;
        case ({mask, k})
            {3'd1, 2'd1}, {3'd2, 2'd0}, {3'd5, 2'd1}, {3'd6, 2'd0}: begin
                s = '{a: 2'd0, b: 2'd1, cut: 1'b1};
            end
            {3'd1, 2'd2}, {3'd3, 2'd2}, {3'd4, 2'd0}, {3'd6, 2'd2}: begin
                s = '{a: 2'd0, b: 2'd2, cut: 1'b1};
            end
            {3'd2, 2'd2}, {3'd3, 2'd3}, {3'd4, 2'd1}, {3'd5, 2'd3}: begin
                s = '{a: 2'd1, b: 2'd2, cut: 1'b1};
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    function automatic vtx_t pick(input vtx_t v0, input vtx_t v1, input vtx_t v2,
                                  input logic [1:0] idx);
        vtx_t r;
        case (idx)
            2'd0:    r = v0;
            2'd1:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    // One restoring division step against the divisor shifted left by j.
    function automatic qs_t qstep(input logic [REM_W-1:0] rem, input logic [DSOR_W-1:0] dsor,
                                  input int unsigned j);
        logic [CMP_W-1:0] sh;
        qs_t              r;
        sh    = CMP_W'(dsor) << j;
        r.hit = CMP_W'(rem) >= sh;
        r.rem = r.hit ? REM_W'(CMP_W'(rem) - sh) : rem;
        return r;
    endfunction

    function automatic logic [31:0] sat_q(input logic neg, input logic ovf,
                                          input logic [31:0] q);
        logic [31:0] r;
        if (ovf || q[31]) begin
            r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            r = neg ? (~q + 32'd1) : q;
        end
        return r;
    endfunction

endpackage

[sv/near_plane_triangle_clipper_core.sv]
`timescale 1ns / 1ps
// Near-plane triangle clipper with perspective divide. Each request carries one clip-space
// triangle (x, y, z, w per vertex, signed Q16.16); the block tests every vertex against the
// plane w + z = 0, clips the crossing edges and sends out a strip of 0, 3 or 4 screen
// vertices, one result per vertex, tagged with its slot and a last flag on the final one.
// A triangle occupies the input sequencer until its last vertex is issued (a triangle with
// no visible vertex is dropped on acceptance); the sequencer feeds one vertex per cycle
// into the pipeline while the output does not stall. From acceptance of a triangle to its
// first vertex, the path runs through a setup register and a 17-stage edge-parameter
// divider, two interpolation stages, a setup register and a 32-stage divider for the three
// screen values, and the output register.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module near_plane_triangle_clipper_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_v0_x,
    input  logic signed [31:0] s_v0_y,
    input  logic signed [31:0] s_v0_z,
    input  logic signed [31:0] s_v0_w,
    input  logic signed [31:0] s_v1_x,
    input  logic signed [31:0] s_v1_y,
    input  logic signed [31:0] s_v1_z,
    input  logic signed [31:0] s_v1_w,
    input  logic signed [31:0] s_v2_x,
    input  logic signed [31:0] s_v2_y,
    input  logic signed [31:0] s_v2_z,
    input  logic signed [31:0] s_v2_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [1:0]         m_slot,
    output logic               m_last
);
    import np_clip_pkg::*;

    // Payload of the edge-parameter divider stages.
    typedef struct packed {
        vtx_t             a;
        vtx_t             b;
        logic [REM_W-1:0] rem;
        logic [33:0]      dsor;
        logic [TQ_BITS-1:0] q;
        logic             cut;
        logic [1:0]       slot;
        logic             last;
    } tdiv_t;

    // Interpolation products.
    typedef struct packed {
        vtx_t               a;
        logic signed [50:0] px;
        logic signed [50:0] py;
        logic signed [50:0] pz;
        logic signed [50:0] pw;
        logic [1:0]         slot;
        logic               last;
    } lerp_t;

    // Clipped vertex, wide enough for an extrapolated cut.
    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [34:0] z;
        logic signed [34:0] w;
        logic [1:0]         slot;
        logic               last;
    } cvtx_t;

    // Payload of the screen divider stages: three lanes share the slot tags.
    typedef struct packed {
        logic [REM_W-1:0]   rx;
        logic [REM_W-1:0]   ry;
        logic [REM_W-1:0]   rz;
        logic [DSOR_W-1:0]  dw;
        logic [DSOR_W-1:0]  dz;
        logic [OQ_BITS-1:0] qx;
        logic [OQ_BITS-1:0] qy;
        logic [OQ_BITS-1:0] qz;
        logic               ox;
        logic               oy;
        logic               oz;
        logic               nx;
        logic               ny;
        logic               nz;
        logic [1:0]         slot;
        logic               last;
    } sdiv_t;

    // The whole pipeline moves whenever the output register can take a new value.
    logic en;
    assign en = !m_valid || m_ready;

    // ---------------- Input sequencer ----------------
    vtx_t       v0_reg, v1_reg, v2_reg;
    logic [2:0] mask_reg;
    logic [1:0] k_reg;
    logic       busy_reg;

    logic       four;
    logic       last_slot;
    logic       issue;
    logic       accept;
    logic [2:0] in_mask;

    assign four      = (mask_reg == 3'd3) || (mask_reg == 3'd5) || (mask_reg == 3'd6);
    assign last_slot = four ? (k_reg == 2'd3) : (k_reg == 2'd2);
    assign issue     = busy_reg && en;
    assign s_ready   = en && (!busy_reg || last_slot);
    assign accept    = s_valid && s_ready;

    always_comb begin
        in_mask[0] = ($signed({s_v0_z[31], s_v0_z}) + $signed({s_v0_w[31], s_v0_w})) > 33'sd0;
        in_mask[1] = ($signed({s_v1_z[31], s_v1_z}) + $signed({s_v1_w[31], s_v1_w})) > 33'sd0;
        in_mask[2] = ($signed({s_v2_z[31], s_v2_z}) + $signed({s_v2_w[31], s_v2_w})) > 33'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= 2'd0;
            mask_reg <= 3'd0;
        end else begin
            if (accept) begin
                // A triangle with nothing visible is taken and dropped here.
                busy_reg <= (in_mask != 3'd0);
                mask_reg <= in_mask;
                k_reg    <= 2'd0;
            end else if (issue) begin
                if (last_slot) begin
                    busy_reg <= 1'b0;
                end else begin
                    k_reg <= k_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            v0_reg <= '{x: s_v0_x, y: s_v0_y, z: s_v0_z, w: s_v0_w};
            v1_reg <= '{x: s_v1_x, y: s_v1_y, z: s_v1_z, w: s_v1_w};
            v2_reg <= '{x: s_v2_x, y: s_v2_y, z: s_v2_z, w: s_v2_w};
        end
    end

    // Setup of the edge parameter t = |dA| / |dB - dA| for the issued vertex.
    src_t               src;
    vtx_t               va, vb;
    logic signed [32:0] da, db;
    logic signed [33:0] dd;
    logic [33:0]        dmag;
    logic [32:0]        damag;
    tdiv_t              tdiv_in;

    always_comb begin
        src   = slot_src(mask_reg, k_reg);
        va    = pick(v0_reg, v1_reg, v2_reg, src.a);
        vb    = pick(v0_reg, v1_reg, v2_reg, src.b);
        da    = $signed({va.w[31], va.w}) + $signed({va.z[31], va.z});
        db    = $signed({vb.w[31], vb.w}) + $signed({vb.z[31], vb.z});
        dd    = $signed({db[32], db}) - $signed({da[32], da});
        dmag  = dd[33] ? 34'(-dd) : 34'(dd);
        damag = da[32] ? 33'(-da) : 33'(da);
        tdiv_in.a    = va;
        tdiv_in.b    = vb;
        tdiv_in.rem  = REM_W'({damag, 16'h0000});
        tdiv_in.dsor = (dmag == 34'd0) ? 34'd1 : dmag;
        tdiv_in.q    = '0;
        tdiv_in.cut  = src.cut;
        tdiv_in.slot = k_reg;
        tdiv_in.last = last_slot;
    end

    // ---------------- Edge-parameter divider, one quotient bit per stage ----------------
    tdiv_t tdiv_reg     [0:TQ_BITS];
    logic  tdiv_vld_reg [0:TQ_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tdiv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            tdiv_vld_reg[0] <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdiv_reg[0] <= tdiv_in;
        end
    end

    for (genvar i = 0; i < TQ_BITS; i++) begin : g_tdiv
        qs_t   st;
        tdiv_t nx;
        always_comb begin
            st = qstep(tdiv_reg[i].rem, DSOR_W'(tdiv_reg[i].dsor), TQ_BITS - 1 - i);
            nx = tdiv_reg[i];
            nx.rem = st.rem;
            nx.q[TQ_BITS-1-i] = st.hit;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tdiv_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                tdiv_vld_reg[i+1] <= tdiv_vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                tdiv_reg[i+1] <= nx;
            end
        end
    end

    // ---------------- Interpolation: products, then add ----------------
    tdiv_t              tq;
    logic signed [17:0] t;
    lerp_t              lerp_next;
    lerp_t              lerp_reg;
    logic               lerp_vld_reg;

    assign tq = tdiv_reg[TQ_BITS];

    always_comb begin
        // A plain vertex goes through with t = 0.
        t = tq.cut ? $signed({1'b0, tq.q} + 18'd1) : 18'sd0;
        lerp_next.a    = tq.a;
        lerp_next.px   = ($signed({tq.b.x[31], tq.b.x}) - $signed({tq.a.x[31], tq.a.x})) * t;
        lerp_next.py   = ($signed({tq.b.y[31], tq.b.y}) - $signed({tq.a.y[31], tq.a.y})) * t;
        lerp_next.pz   = ($signed({tq.b.z[31], tq.b.z}) - $signed({tq.a.z[31], tq.a.z})) * t;
        lerp_next.pw   = ($signed({tq.b.w[31], tq.b.w}) - $signed({tq.a.w[31], tq.a.w})) * t;
        lerp_next.slot = tq.slot;
        lerp_next.last = tq.last;
    end

    cvtx_t cv_next;
    cvtx_t cv_reg;
    logic  cv_vld_reg;

    always_comb begin
        // The arithmetic shift floors, as the edge blend requires.
        cv_next.x    = 35'(lerp_reg.a.x) + 35'(lerp_reg.px >>> Q_FRAC);
        cv_next.y    = 35'(lerp_reg.a.y) + 35'(lerp_reg.py >>> Q_FRAC);
        cv_next.z    = 35'(lerp_reg.a.z) + 35'(lerp_reg.pz >>> Q_FRAC);
        cv_next.w    = 35'(lerp_reg.a.w) + 35'(lerp_reg.pw >>> Q_FRAC);
        cv_next.slot = lerp_reg.slot;
        cv_next.last = lerp_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lerp_vld_reg <= 1'b0;
            cv_vld_reg   <= 1'b0;
        end else if (en) begin
            lerp_vld_reg <= tdiv_vld_reg[TQ_BITS];
            cv_vld_reg   <= lerp_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lerp_reg <= lerp_next;
            cv_reg   <= cv_next;
        end
    end

    // ---------------- Screen divide setup ----------------
    // Magnitudes are divided; signs are put back at the end. A quotient of 2^32 or more
    // is flagged up front and saturates.
    logic signed [34:0] wf;
    logic signed [35:0] den;
    logic [34:0]        ax, ay, aw;
    sdiv_t              sd_in;

    always_comb begin
        wf  = (cv_reg.w == 35'sd0) ? 35'sd1 : cv_reg.w;
        den = (wf == Q_ONE_W) ? (NEAR_ONE + 36'(cv_reg.z)) : 36'(wf);
        if (den == 36'sd0) begin
            den = -36'sd1;
        end
        ax = cv_reg.x[34] ? 35'(-cv_reg.x) : 35'(cv_reg.x);
        ay = cv_reg.y[34] ? 35'(-cv_reg.y) : 35'(cv_reg.y);
        aw = wf[34] ? 35'(-wf) : 35'(wf);
        sd_in.rx   = {ax, 16'h0000};
        sd_in.ry   = {ay, 16'h0000};
        sd_in.rz   = REM_W'(1) << OQ_BITS;
        sd_in.dw   = DSOR_W'(aw);
        sd_in.dz   = den[35] ? DSOR_W'(-den) : DSOR_W'(den);
        sd_in.qx   = '0;
        sd_in.qy   = '0;
        sd_in.qz   = '0;
        sd_in.ox   = CMP_W'(sd_in.rx) >= (CMP_W'(sd_in.dw) << OQ_BITS);
        sd_in.oy   = CMP_W'(sd_in.ry) >= (CMP_W'(sd_in.dw) << OQ_BITS);
        sd_in.oz   = CMP_W'(sd_in.rz) >= (CMP_W'(sd_in.dz) << OQ_BITS);
        sd_in.nx   = cv_reg.x[34] ^ wf[34];
        sd_in.ny   = ~(cv_reg.y[34] ^ wf[34]);
        sd_in.nz   = den[35];
        sd_in.slot = cv_reg.slot;
        sd_in.last = cv_reg.last;
    end

    sdiv_t sdiv_reg     [0:OQ_BITS];
    logic  sdiv_vld_reg [0:OQ_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sdiv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sdiv_vld_reg[0] <= cv_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdiv_reg[0] <= sd_in;
        end
    end

    for (genvar i = 0; i < OQ_BITS; i++) begin : g_sdiv
        qs_t   sx, sy, sz;
        sdiv_t nx;
        always_comb begin
            sx = qstep(sdiv_reg[i].rx, sdiv_reg[i].dw, OQ_BITS - 1 - i);
            sy = qstep(sdiv_reg[i].ry, sdiv_reg[i].dw, OQ_BITS - 1 - i);
            sz = qstep(sdiv_reg[i].rz, sdiv_reg[i].dz, OQ_BITS - 1 - i);
            nx = sdiv_reg[i];
            nx.rx = sx.rem;
            nx.ry = sy.rem;
            nx.rz = sz.rem;
            nx.qx[OQ_BITS-1-i] = sx.hit;
            nx.qy[OQ_BITS-1-i] = sy.hit;
            nx.qz[OQ_BITS-1-i] = sz.hit;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sdiv_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                sdiv_vld_reg[i+1] <= sdiv_vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sdiv_reg[i+1] <= nx;
            end
        end
    end

    // ---------------- Output register ----------------
    sdiv_t       sf;
    logic        m_valid_reg;
    logic [31:0] m_out_x_reg, m_out_y_reg, m_out_z_reg;
    logic [1:0]  m_slot_reg;
    logic        m_last_reg;

    assign sf = sdiv_reg[OQ_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sdiv_vld_reg[OQ_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_x_reg <= sat_q(sf.nx, sf.ox, sf.qx);
            m_out_y_reg <= sat_q(sf.ny, sf.oy, sf.qy);
            m_out_z_reg <= sat_q(sf.nz, sf.oz, sf.qz);
            m_slot_reg  <= sf.slot;
            m_last_reg  <= sf.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = $signed(m_out_x_reg);
    assign m_out_y = $signed(m_out_y_reg);
    assign m_out_z = $signed(m_out_z_reg);
    assign m_slot  = m_slot_reg;
    assign m_last  = m_last_reg;

    // ---------------- Assertions ----------------
    // A strip never ends before its third vertex.
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> (m_slot == 2'd2 || m_slot == 2'd3))
        else $error("strip ended early");

    // The fourth vertex is always the last one.
    a_slot3_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slot == 2'd3 |-> m_last)
        else $error("fourth vertex without last");

    // A new triangle is only taken while the pipeline is free to move.
    a_ready_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("request taken during a stall");

    // The sequencer starts every strip at slot zero.
    a_strip_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (k_reg == 2'd0))
        else $error("strip did not start at slot zero");

endmodule
